### design/cdad_pkg.sv
package cdad_pkg;

   // Field widths of the request and response channels.
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int OFFSET_W = 21;

   // Calendar bounds and the constants of the leap-year rule.
   localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1;
   localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
   localparam logic [DAY_W-1:0]   DEC_DAYS    = 5'd31;
   localparam logic [YEAR_W-1:0]  CENTURY     = 14'd100;
   localparam logic [YEAR_W-1:0]  CYCLE_YEARS = 14'd400;
   localparam int                 MONTHS      = 12;

   // Month lengths: common year first, then leap year.
   localparam logic [DAY_W-1:0] MONTH_LEN_TABLE [2*MONTHS] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   // Outcome of one walk step of the shared month unit.
   typedef struct packed {
      date_type            date;
      logic [OFFSET_W-1:0] rem;
      logic [YEAR_W-1:0]   cycle_pos;
      logic                done;
      logic                clamped;
   } step_type;

   // Length of a month (1..12) in a common or leap year.
   function automatic logic [DAY_W-1:0] month_length(input logic leap,
                                                      input logic [MONTH_W-1:0] month);
      logic [4:0] idx;
      idx = leap ? (5'(month) + 5'(MONTHS) - 5'd1) : (5'(month) - 5'd1);
      return MONTH_LEN_TABLE[idx];
   endfunction

endpackage

### design/cdad_step_unit.sv
module cdad_step_unit (
   input  cdad_pkg::date_type                   date,
   input  logic [cdad_pkg::OFFSET_W-1:0]        rem,
   input  logic [cdad_pkg::YEAR_W-1:0]          cycle_pos,
   output logic [cdad_pkg::DAY_W-1:0]           cur_len,
   output cdad_pkg::step_type                   step
);
   import cdad_pkg::*;

   logic                leap;
   logic [DAY_W-1:0]    prev_len;
   logic [DAY_W-1:0]    gap;
   logic [OFFSET_W:0]   back_sum;
   logic                rem_zero;
   logic                rem_neg;
   logic                fits_fwd;
   logic                fits_back;
   logic [YEAR_W-1:0]   pos_inc;
   logic [YEAR_W-1:0]   pos_dec;

   // Leap test: the year's place in the 400-year cycle settles the century rule.
   assign leap = (date.year[1:0] == 2'b00) && (cycle_pos != CENTURY) &&
                 (cycle_pos != 14'(2 * CENTURY)) && (cycle_pos != 14'(3 * CENTURY));

   assign cur_len  = month_length(leap, date.month);
   assign prev_len = (date.month == MONTH_JAN) ? DEC_DAYS
                                               : month_length(leap, date.month - 4'd1);

   // Days left in the current month after the current day.
   assign gap = cur_len - date.day;

   assign rem_zero  = (rem == '0);
   assign rem_neg   = rem[OFFSET_W-1];
   assign fits_fwd  = (rem <= OFFSET_W'(gap));
   assign back_sum  = {rem[OFFSET_W-1], rem} + (OFFSET_W+1)'(date.day);
   assign fits_back = !back_sum[OFFSET_W] && (back_sum != '0);

   assign pos_inc = (cycle_pos == CYCLE_YEARS - 14'd1) ? '0 : cycle_pos + 14'd1;
   assign pos_dec = (cycle_pos == '0) ? CYCLE_YEARS - 14'd1 : cycle_pos - 14'd1;

   // One month boundary per step, forward or backward.
   always_comb begin
      step.date      = date;
      step.rem       = rem;
      step.cycle_pos = cycle_pos;
      step.done      = 1'b0;
      step.clamped   = 1'b0;
      priority if (rem_zero) begin
         step.done = 1'b1;
      end else if (!rem_neg) begin
         if (fits_fwd) begin
            step.date.day = date.day + rem[DAY_W-1:0];
            step.rem      = '0;
            step.done     = 1'b1;
         end else begin
            step.rem      = rem - OFFSET_W'(gap) - OFFSET_W'(1);
            step.date.day = DAY_FIRST;
            if (date.month == MONTH_DEC) begin
               if (date.year == YEAR_MAX) begin
                  step.date.day = DEC_DAYS;
                  step.done     = 1'b1;
                  step.clamped  = 1'b1;
               end else begin
                  step.date.year  = date.year + 14'd1;
                  step.date.month = MONTH_JAN;
                  step.cycle_pos  = pos_inc;
               end
            end else begin
               step.date.month = date.month + 4'd1;
            end
         end
      end else begin
         if (fits_back) begin
            step.date.day = back_sum[DAY_W-1:0];
            step.rem      = '0;
            step.done     = 1'b1;
         end else begin
            step.rem = back_sum[OFFSET_W-1:0];
            if (date.month == MONTH_JAN) begin
               if (date.year == YEAR_MIN) begin
                  step.date.day = DAY_FIRST;
                  step.done     = 1'b1;
                  step.clamped  = 1'b1;
               end else begin
                  step.date.year  = date.year - 14'd1;
                  step.date.month = MONTH_DEC;
                  step.date.day   = DEC_DAYS;
                  step.cycle_pos  = pos_dec;
               end
            end else begin
               step.date.month = date.month - 4'd1;
               step.date.day   = prev_len;
            end
         end
      end
   end

endmodule

### design/calendar_date_add_days.sv
// Gregorian date plus a signed day offset.
// Request channel: drive req_start_year, req_start_month, req_start_day and
// req_day_offset with start high; the transfer takes place at a rising edge
// where start is high and busy is low. busy stays high until the result is out.
// Response channel: rsp_strobe is high for exactly one cycle with the result
// date and rsp_out_of_range on the rsp_ ports. The receiver cannot stall, so
// the result must be taken in that cycle.
// Operation: the start year is reduced modulo 400 by repeated subtraction in
// ST_REDUCE, the start day is clamped in ST_CLAMP, and then in ST_WALK the
// shared month unit crosses one month boundary per cycle until the offset is
// used up. One item is in flight at a time, and busy falls as the strobe
// rises, so a new request can be transferred at the edge that ends the
// strobe cycle.
// A result outside years 1..9999 clamps to 0001-01-01 or 9999-12-31 with
// rsp_out_of_range set. Out-of-range start fields are clamped to valid values.
// Reset is synchronous: it returns the block to idle and drops the strobe.
module calendar_date_add_days (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cdad_pkg::YEAR_W-1:0]         req_start_year,
   input  logic [cdad_pkg::MONTH_W-1:0]        req_start_month,
   input  logic [cdad_pkg::DAY_W-1:0]          req_start_day,
   input  logic signed [cdad_pkg::OFFSET_W-1:0] req_day_offset,
   output logic                                rsp_strobe,
   output logic [cdad_pkg::YEAR_W-1:0]         rsp_result_year,
   output logic [cdad_pkg::MONTH_W-1:0]        rsp_result_month,
   output logic [cdad_pkg::DAY_W-1:0]          rsp_result_day,
   output logic                                rsp_out_of_range
);
   import cdad_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_REDUCE = 4'b0010,
      ST_CLAMP  = 4'b0100,
      ST_WALK   = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   date_type            date_ff, date_in;
   logic [OFFSET_W-1:0] rem_ff, rem_in;
   logic [YEAR_W-1:0]   pos_ff, pos_in;
   logic                strobe_ff, strobe_in;
   date_type            res_ff, res_in;
   logic                oor_ff, oor_in;

   logic                accept;
   date_type            start_date;
   logic [DAY_W-1:0]    cur_len;
   step_type            step;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Year and month clamps of the incoming date.
   always_comb begin
      start_date.year  = req_start_year;
      start_date.month = req_start_month;
      start_date.day   = req_start_day;
      if (req_start_year < YEAR_MIN) start_date.year = YEAR_MIN;
      if (req_start_year > YEAR_MAX) start_date.year = YEAR_MAX;
      if (req_start_month < MONTH_JAN) start_date.month = MONTH_JAN;
      if (req_start_month > MONTH_DEC) start_date.month = MONTH_DEC;
   end

   // Shared month unit.
   cdad_step_unit u_step (
      .date      (date_ff),
      .rem       (rem_ff),
      .cycle_pos (pos_ff),
      .cur_len   (cur_len),
      .step      (step)
   );

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      date_in   = date_ff;
      rem_in    = rem_ff;
      pos_in    = pos_ff;
      strobe_in = 1'b0;
      res_in    = res_ff;
      oor_in    = oor_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               date_in  = start_date;
               rem_in   = req_day_offset;
               pos_in   = start_date.year;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (pos_ff >= CYCLE_YEARS) begin
               pos_in = pos_ff - CYCLE_YEARS;
            end else begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (date_ff.day < DAY_FIRST) date_in.day = DAY_FIRST;
            if (date_ff.day > cur_len) date_in.day = cur_len;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            date_in = step.date;
            rem_in  = step.rem;
            pos_in  = step.cycle_pos;
            if (step.done) begin
               res_in    = step.date;
               oor_in    = step.clamped;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      date_ff <= date_in;
      rem_ff  <= rem_in;
      pos_ff  <= pos_in;
      res_ff  <= res_in;
      oor_ff  <= oor_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_result_year  = res_ff.year;
   assign rsp_result_month = res_ff.month;
   assign rsp_result_day   = res_ff.day;
   assign rsp_out_of_range = oor_ff;

`ifndef SYNTHESIS
   // A transfer always starts a busy period.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy did not rise after a request transfer");

   // The result appears as the block goes back to idle, for one cycle only.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(busy))
      else $error("result strobe without a finished walk");

   // A clamped result is one of the two calendar bounds.
   a_clamp_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_out_of_range |->
         (rsp_result_year == YEAR_MIN && rsp_result_month == MONTH_JAN &&
          rsp_result_day == DAY_FIRST) ||
         (rsp_result_year == YEAR_MAX && rsp_result_month == MONTH_DEC &&
          rsp_result_day == DEC_DAYS))
      else $error("clamped result is not a calendar bound");

   // While walking, the cycle position is reduced and the day is a real day.
   a_walk_state: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> pos_ff < CYCLE_YEARS && date_ff.day != '0 &&
                              date_ff.day <= cur_len)
      else $error("walk state holds an unreduced year or a bad day");

   // The year position tracks the year across every walk step.
   a_pos_track: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK && !step.done && step.date.year != date_ff.year |=>
         pos_ff != $past(pos_ff))
      else $error("year changed without moving the cycle position");
`endif

endmodule
